[rtl/core/prf_pkg.sv]
// ----------------------------------------------------------------------------
// prf_pkg: shared constants and types of the polynomial root finder
// widths, register indexes, status codes and fixed-point helpers
// ----------------------------------------------------------------------------
package prf_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned TolW       = 31;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned NumCoef    = 6;

  localparam int unsigned MaxTermsDef = 6;
  localparam int unsigned MaxIterDef  = 64;
  localparam int unsigned FracBitsDef = 16;

  localparam logic [TolW-1:0] TolReset = TolW'(66);

  localparam logic [CfgIdxW-1:0] RegTol = 3'd6;

  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StNoSign  = 2'd1;
  localparam logic [StatusW-1:0] StZeroDer = 2'd2;
  localparam logic [StatusW-1:0] StIterCap = 2'd3;

  typedef logic signed [DataW-1:0] word_t;

  // saturate a 66-bit signed value to 32 bits
  function automatic word_t sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

[rtl/core/prf_div.sv]
// ----------------------------------------------------------------------------
// prf_div: signed restoring divider, one quotient bit a cycle
// computes trunc((num << frac_bits) / den), saturated to 32 bits
// ----------------------------------------------------------------------------
module prf_div #(
  parameter int unsigned FracBits = prf_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  prf_pkg::word_t      num_i,
  input  prf_pkg::word_t      den_i,
  output logic                done_o,
  output prf_pkg::word_t      quot_o
);
  localparam int unsigned NumW = 32 + FracBits;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] n_q, n_d;
  logic [NumW-1:0] q_q, q_d;
  logic [32:0]     r_q, r_d;
  logic [31:0]     dm_q, dm_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [32:0]     shifted;
  logic [NumW:0]   qmag;

  always_comb begin
    n_d = n_q; q_d = q_q; r_d = r_q; dm_d = dm_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    shifted = {r_q[31:0], n_q[NumW-1]};
    if (start_i) begin
      n_d   = {(num_i[31] ? 32'(-num_i) : 32'(num_i)), FracBits'(0)};
      dm_d  = den_i[31] ? 32'(-den_i) : 32'(den_i);
      neg_d = num_i[31] ^ den_i[31];
      q_d   = '0;
      r_d   = '0;
      cnt_d = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      n_d = {n_q[NumW-2:0], 1'b0};
      if (shifted >= {1'b0, dm_q}) begin
        r_d = shifted - {1'b0, dm_q};
        q_d = {q_q[NumW-2:0], 1'b1};
      end else begin
        r_d = shifted;
        q_d = {q_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; q_q <= q_d; r_q <= r_d; dm_q <= dm_d; neg_q <= neg_d;
  end

  // magnitude of num<<frac may reach 2^(31+frac), so widen before sign
  assign qmag   = {1'b0, q_q};
  assign done_o = done_q;
  assign quot_o = prf_pkg::sat32(neg_q ? -$signed(66'(qmag)) : $signed(66'(qmag)));
endmodule

[rtl/core/prf_mac.sv]
// ----------------------------------------------------------------------------
// prf_mac: shared fixed-point multiplier with floor shift and saturation
// one registered product per cycle
// ----------------------------------------------------------------------------
module prf_mac #(
  parameter int unsigned FracBits = prf_pkg::FracBitsDef
) (
  input  logic           clk_i,
  input  prf_pkg::word_t a_i,
  input  prf_pkg::word_t b_i,
  output prf_pkg::word_t p_o
);
  logic signed [63:0] prod;
  prf_pkg::word_t     p_q;

  // arithmetic shift right floors toward minus infinity
  assign prod = 64'(a_i) * 64'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= prf_pkg::sat32(66'(prod >>> FracBits));
  end

  assign p_o = p_q;
endmodule

[rtl/core/polynomial_root_finder.sv]
// ----------------------------------------------------------------------------
// polynomial_root_finder: bisection and newton root finder, Q16.16
// one shared multiplier and one serial divider under a small sequencer
// ----------------------------------------------------------------------------
// usage
//   write coef_0..coef_5 (index 0..5) and tolerance (index 6) on the cfg
//   channel while the block is idle; other indexes are dropped
//   a request is taken when start is high and busy is low; busy stays
//   high through the result strobe done_o, which lasts one cycle and carries
//   status_o, bisection_root_o and newton_root_o
// operation
//   every polynomial evaluation runs each term through the shared
//   multiplier (product, sum, power step) and then returns; a bisection
//   step is one evaluation, a newton step two evaluations plus a serial
//   division; one request runs at most MaxIter steps of each method.
// reset
//   coefficients clear to zero, tolerance to about 0.001, sequencer idles
// the receiver cannot stall; a result is shown in its strobe cycle only
// ----------------------------------------------------------------------------
module polynomial_root_finder #(
  parameter int unsigned MaxTerms = prf_pkg::MaxTermsDef,
  parameter int unsigned MaxIter  = prf_pkg::MaxIterDef,
  parameter int unsigned FracBits = prf_pkg::FracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  output logic                            done_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [prf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  input  logic signed [31:0]              range_low_i,
  input  logic signed [31:0]              range_high_i,
  output logic [prf_pkg::StatusW-1:0]     status_o,
  output logic signed [31:0]              bisection_root_o,
  output logic signed [31:0]              newton_root_o
);
  localparam int unsigned TermW = $clog2(prf_pkg::NumCoef + 1);
  localparam int unsigned IterW = $clog2(MaxIter + 1);
  localparam int unsigned NTerm = (MaxTerms < prf_pkg::NumCoef) ? MaxTerms : prf_pkg::NumCoef;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EVAL   = 4'd1;  // issue term product
  localparam logic [3:0] S_ACC    = 4'd2;  // add product, issue power step
  localparam logic [3:0] S_PWR    = 4'd3;  // capture power
  localparam logic [3:0] S_FA     = 4'd4;
  localparam logic [3:0] S_FB     = 4'd5;
  localparam logic [3:0] S_BMID   = 4'd6;
  localparam logic [3:0] S_NF     = 4'd7;
  localparam logic [3:0] S_ND     = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_NSTEP  = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;
  localparam logic [3:0] S_NSTART = 4'd12;
  localparam logic [3:0] S_BSTEP  = 4'd13;

  prf_pkg::word_t coef_q [prf_pkg::NumCoef];
  logic [prf_pkg::TolW-1:0] tol_q;

  logic [3:0] st_q, st_d, ret_q, ret_d;
  prf_pkg::word_t a_q, a_d, b_q, b_d, fa_q, fa_d;
  prf_pkg::word_t x_q, x_d, ex_q, ex_d, pw_q, pw_d, sum_q, sum_d;
  prf_pkg::word_t f_q, f_d, br_q, br_d;
  logic [TermW-1:0] term_q, term_d;
  logic [IterW-1:0] it_q, it_d;
  logic deriv_q, deriv_d;
  logic [prf_pkg::StatusW-1:0] stat_q, stat_d;
  logic done_q, done_d;

  prf_pkg::word_t ma, mb, mp, quot, coef_sel, dcoef, mid, nx;
  logic mul_a_pwr;
  logic div_start, div_done;
  logic signed [65:0] wsum, tol_s;

  prf_mac #(.FracBits(FracBits)) u_mac (
    .clk_i (clk_i), .a_i (ma), .b_i (mb), .p_o (mp)
  );

  prf_div #(.FracBits(FracBits)) u_div (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .num_i (f_q), .den_i (sum_q), .done_o (div_done), .quot_o (quot)
  );

  // config channel is always open; by contract writes come only while idle, which the block itself does not enforce
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < prf_pkg::NumCoef; i++) coef_q[i] <= '0;
      tol_q <= prf_pkg::TolReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i < prf_pkg::RegTol) begin
        coef_q[cfg_index_i] <= cfg_data_i;
      end else if (cfg_index_i == prf_pkg::RegTol) begin
        tol_q <= cfg_data_i[prf_pkg::TolW-1:0];
      end
    end
  end

  assign tol_s = 66'($unsigned(tol_q));

  // coefficient for the current term; derivative uses i*coef_i
  always_comb begin
    coef_sel = '0;
    for (int i = 0; i < prf_pkg::NumCoef; i++) begin
      if (term_q == TermW'(i)) coef_sel = coef_q[i];
    end
    dcoef = prf_pkg::sat32(66'(coef_sel) * $signed(66'(term_q)));
  end

  function automatic logic [1:0] sgn(input prf_pkg::word_t v);
    sgn = (v == '0) ? 2'b00 : (v[31] ? 2'b11 : 2'b01);
  endfunction

  function automatic logic signed [65:0] abs66(input logic signed [65:0] v);
    abs66 = v[65] ? -v : v;
  endfunction

  always_comb begin
    mul_a_pwr = (st_q == S_ACC);
    ma = mul_a_pwr ? pw_q : (deriv_q ? dcoef : coef_sel);
    mb = mul_a_pwr ? ex_q : pw_q;
    wsum = 66'(a_q) + 66'(b_q);
    mid = wsum[32:1];
    nx = prf_pkg::sat32(66'(x_q) - 66'(quot));
  end

  always_comb begin
    st_d = st_q; ret_d = ret_q; a_d = a_q; b_d = b_q; fa_d = fa_q;
    x_d = x_q; ex_d = ex_q; pw_d = pw_q; sum_d = sum_q; f_d = f_q; br_d = br_q;
    term_d = term_q; it_d = it_q; deriv_d = deriv_q; stat_d = stat_q;
    done_d = 1'b0; div_start = 1'b0;
    case (st_q)
      S_IDLE: begin
        // no new request while the result strobe is still up
        if (start && !done_q) begin
          a_d = range_low_i; b_d = range_high_i;
          ex_d = range_low_i; deriv_d = 1'b0; ret_d = S_FA;
          pw_d = prf_pkg::sat32(66'sd1 <<< FracBits);
          sum_d = '0; term_d = '0; st_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (term_q >= TermW'(NTerm)) begin
          st_d = ret_q;
        end else if (deriv_q && term_q == '0) begin
          // derivative skips the constant term but keeps the power at 1
          term_d = TermW'(1); st_d = S_EVAL;
        end else begin
          st_d = S_ACC;
        end
      end
      S_ACC: begin
        sum_d = prf_pkg::sat32(66'(sum_q) + 66'(mp));
        st_d = S_PWR;
      end
      S_PWR: begin
        // derivative power starts at 1 for term 1; the power steps after every term
        if (!(deriv_q && term_q == TermW'(1) && 1'b0)) pw_d = mp;
        term_d = term_q + TermW'(1);
        st_d = S_EVAL;
      end
      S_FA: begin
        fa_d = sum_q; ex_d = b_q; ret_d = S_FB;
        pw_d = prf_pkg::sat32(66'sd1 <<< FracBits); sum_d = '0; term_d = '0;
        st_d = S_EVAL;
      end
      S_FB: begin
        it_d = '0; br_d = '0;
        if (!(sgn(fa_q) == 2'b01 && sgn(sum_q) == 2'b11) &&
            !(sgn(fa_q) == 2'b11 && sgn(sum_q) == 2'b01)) begin
          stat_d = prf_pkg::StNoSign; st_d = S_NSTART;
        end else begin
          stat_d = prf_pkg::StOk; st_d = S_BSTEP;
        end
      end
      S_BSTEP: begin
        if (it_q == IterW'(MaxIter)) begin
          stat_d = prf_pkg::StIterCap; st_d = S_NSTART;
        end else begin
          ex_d = mid; br_d = mid; ret_d = S_BMID;
          pw_d = prf_pkg::sat32(66'sd1 <<< FracBits); sum_d = '0; term_d = '0;
          st_d = S_EVAL;
        end
      end
      S_BMID: begin
        if (sum_q == '0 || abs66(66'(a_q) - 66'(b_q)) < tol_s) begin
          st_d = S_NSTART;
        end else begin
          if (sgn(sum_q) == sgn(fa_q)) begin
            a_d = br_q; fa_d = sum_q;
          end else begin
            b_d = br_q;
          end
          it_d = it_q + IterW'(1);
          st_d = S_BSTEP;
        end
      end
      S_NSTART: begin
        x_d = prf_pkg::sat32(66'sd1 <<< FracBits); it_d = '0;
        ex_d = prf_pkg::sat32(66'sd1 <<< FracBits);
        deriv_d = 1'b0; ret_d = S_NF;
        pw_d = prf_pkg::sat32(66'sd1 <<< FracBits); sum_d = '0; term_d = '0;
        st_d = S_EVAL;
      end
      S_NF: begin
        f_d = sum_q;
        if (abs66(66'(sum_q)) <= tol_s) begin
          st_d = S_OUT;
        end else begin
          deriv_d = 1'b1; ret_d = S_ND;
          pw_d = prf_pkg::sat32(66'sd1 <<< FracBits); sum_d = '0; term_d = '0;
          st_d = S_EVAL;
        end
      end
      S_ND: begin
        if (sum_q == '0) begin
          if (stat_q == prf_pkg::StOk) stat_d = prf_pkg::StZeroDer;
          st_d = S_OUT;
        end else begin
          div_start = 1'b1; st_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) st_d = S_NSTEP;
      end
      S_NSTEP: begin
        if (abs66(66'(nx) - 66'(x_q)) <= tol_s) begin
          st_d = S_OUT;
        end else if (it_q == IterW'(MaxIter - 1)) begin
          x_d = nx;
          if (stat_q == prf_pkg::StOk) stat_d = prf_pkg::StIterCap;
          st_d = S_OUT;
        end else begin
          x_d = nx; ex_d = nx; it_d = it_q + IterW'(1);
          deriv_d = 1'b0; ret_d = S_NF;
          pw_d = prf_pkg::sat32(66'sd1 <<< FracBits); sum_d = '0; term_d = '0;
          st_d = S_EVAL;
        end
      end
      S_OUT: begin
        done_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ret_q <= S_IDLE; done_q <= 1'b0;
      term_q <= '0; it_q <= '0; deriv_q <= 1'b0; stat_q <= prf_pkg::StOk;
    end else begin
      st_q <= st_d; ret_q <= ret_d; done_q <= done_d;
      term_q <= term_d; it_q <= it_d; deriv_q <= deriv_d; stat_q <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; fa_q <= fa_d; x_q <= x_d; ex_q <= ex_d;
    pw_q <= pw_d; sum_q <= sum_d; f_q <= f_d; br_q <= br_d;
  end

  assign busy = (st_q != S_IDLE) || done_q;
  assign done_o = done_q;
  assign status_o = stat_q;
  assign bisection_root_o = br_q;
  assign newton_root_o = x_q;
endmodule

[dv/polynomial_root_finder_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polynomial_root_finder_checker: result predictor and scoreboard
// watches the cfg channel, the request handshake and the result strobe,
// predicts status and both roots per request and compares in order
// ----------------------------------------------------------------------------
module polynomial_root_finder_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               busy_i,
  input  logic                               done_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [prf_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  input  logic signed [31:0]                 range_low_i,
  input  logic signed [31:0]                 range_high_i,
  input  logic [prf_pkg::StatusW-1:0]        status_i,
  input  logic signed [31:0]                 bisection_root_i,
  input  logic signed [31:0]                 newton_root_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 checked_o
);

  localparam int unsigned IterLimit = prf_pkg::MaxIterDef;
  localparam int unsigned FracQ     = prf_pkg::FracBitsDef;

  typedef struct packed {
    logic [prf_pkg::StatusW-1:0] status;
    logic signed [31:0]          bis_root;
    logic signed [31:0]          newt_root;
  } roots_t;

  prf_pkg::word_t  coef_q[prf_pkg::NumCoef];
  longint          tol_q;
  roots_t          expected_roots[$];

  function automatic prf_pkg::word_t clamp32(input longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return prf_pkg::word_t'(v);
  endfunction

  // product shifted right with floor rounding, then saturated
  function automatic prf_pkg::word_t qmul(input prf_pkg::word_t a, input prf_pkg::word_t b);
    return clamp32((longint'(a) * longint'(b)) >>> FracQ);
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic prf_pkg::word_t eval_poly(input prf_pkg::word_t x);
    prf_pkg::word_t sum, pw;
    sum = '0;
    pw  = clamp32(64'sd1 <<< FracQ);
    for (int i = 0; i < prf_pkg::MaxTermsDef; i++) begin
      sum = clamp32(longint'(sum) + longint'(qmul(coef_q[i], pw)));
      pw  = qmul(pw, x);
    end
    return sum;
  endfunction

  function automatic prf_pkg::word_t eval_slope(input prf_pkg::word_t x);
    prf_pkg::word_t sum, pw, c;
    sum = '0;
    pw  = clamp32(64'sd1 <<< FracQ);
    for (int i = 1; i < prf_pkg::MaxTermsDef; i++) begin
      c   = clamp32(longint'(coef_q[i]) * i);
      sum = clamp32(longint'(sum) + longint'(qmul(c, pw)));
      pw  = qmul(pw, x);
    end
    return sum;
  endfunction

  function automatic int sign_of(input prf_pkg::word_t v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic roots_t find_roots(input prf_pkg::word_t lo, input prf_pkg::word_t hi);
    roots_t r;
    prf_pkg::word_t a, b, fa, fb, mid, fm, x, f, d, nx;
    logic [prf_pkg::StatusW-1:0] nstat;
    logic   settled;
    a = lo;
    b = hi;
    fa = eval_poly(a);
    fb = eval_poly(b);
    r.status   = prf_pkg::StOk;
    r.bis_root = '0;
    // bisection needs strictly opposite signs at the ends
    if (!(sign_of(fa) * sign_of(fb) < 0)) begin
      r.status = prf_pkg::StNoSign;
    end else begin
      settled = 1'b0;
      for (int k = 0; k < IterLimit; k++) begin
        mid = prf_pkg::word_t'((longint'(a) + longint'(b)) >>> 1);
        fm  = eval_poly(mid);
        r.bis_root = mid;
        if (fm == 0 || mag(longint'(a) - longint'(b)) < tol_q) begin
          settled = 1'b1;
          break;
        end
        if (sign_of(fm) == sign_of(fa)) begin
          a  = mid;
          fa = fm;
        end else begin
          b = mid;
        end
      end
      if (!settled) r.status = prf_pkg::StIterCap;
    end
    // newton from 1.0
    x = clamp32(64'sd1 <<< FracQ);
    nstat = prf_pkg::StIterCap;
    for (int k = 0; k < IterLimit; k++) begin
      f = eval_poly(x);
      if (mag(longint'(f)) <= tol_q) begin
        nstat = prf_pkg::StOk;
        break;
      end
      d = eval_slope(x);
      if (d == 0) begin
        nstat = prf_pkg::StZeroDer;
        break;
      end
      nx = clamp32(longint'(x) -
                   longint'(clamp32((longint'(f) <<< FracQ) / longint'(d))));
      if (mag(longint'(nx) - longint'(x)) <= tol_q) begin
        nstat = prf_pkg::StOk;
        break;
      end
      x = nx;
    end
    if (r.status == prf_pkg::StOk) r.status = nstat;
    r.newt_root = x;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    roots_t want;
    if (!rst_ni) begin
      for (int i = 0; i < prf_pkg::NumCoef; i++) coef_q[i] = '0;
      tol_q = longint'(prf_pkg::TolReset);
      expected_roots.delete();
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      // register writes, unused indexes dropped
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i < prf_pkg::NumCoef) begin
          coef_q[cfg_index_i] = cfg_data_i;
        end else if (cfg_index_i == prf_pkg::RegTol) begin
          tol_q = longint'(cfg_data_i[prf_pkg::TolW-1:0]);
        end
      end
      if (done_i) begin
        if (expected_roots.size() == 0) begin
          $error("result strobe with no request outstanding");
          fail_count_o++;
        end else begin
          want = expected_roots.pop_front();
          checked_o++;
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_count_o++;
          end
          if (bisection_root_i !== want.bis_root) begin
            $error("bisection_root: expected %0d, got %0d", want.bis_root,
                   bisection_root_i);
            fail_count_o++;
          end
          if (newton_root_i !== want.newt_root) begin
            $error("newton_root: expected %0d, got %0d", want.newt_root,
                   newton_root_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_roots.push_back(find_roots(range_low_i, range_high_i));
      end
    end
  end

  assign pending_o = expected_roots.size();

endmodule

[dv/polynomial_root_finder_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polynomial_root_finder_tb: top of the root finder testbench
// drives directed and random search intervals over many coefficient and
// tolerance settings; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module polynomial_root_finder_tb;

  localparam logic [prf_pkg::CfgIdxW-1:0] RegCoef0  = 3'd0;
  localparam logic [prf_pkg::CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int                          One       = 1 << prf_pkg::FracBitsDef;
  localparam int                          NumPhases = 6;
  localparam int                          PerPhase  = 95;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start = 1'b0;
  logic                            busy, done;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [prf_pkg::CfgIdxW-1:0]     cfg_index = '0;
  logic [31:0]                     cfg_data = '0;
  logic signed [31:0]              range_low = '0;
  logic signed [31:0]              range_high = '0;
  logic [prf_pkg::StatusW-1:0]     status;
  logic signed [31:0]              bisection_root, newton_root;

  int fail_count, pending, checked;
  int n_requests, n_settings, burst_left;
  // handshakes seen at the last rising edge, read at the falling edge
  logic req_taken, cfg_taken;

  always #1 clk_i = ~clk_i;

  polynomial_root_finder u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .done_o           (done),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .range_low_i      (range_low),
    .range_high_i     (range_high),
    .status_o         (status),
    .bisection_root_o (bisection_root),
    .newton_root_o    (newton_root)
  );

  polynomial_root_finder_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .done_i           (done),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .range_low_i      (range_low),
    .range_high_i     (range_high),
    .status_i         (status),
    .bisection_root_i (bisection_root),
    .newton_root_i    (newton_root),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      req_taken <= start && !busy;
      cfg_taken <= cfg_valid && cfg_ready;
    end
  end

  // wait at a falling edge until every result is back and the block is idle
  task automatic drain();
    start = 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy);
  endtask

  task automatic write_reg(input logic [prf_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid = 1'b0;
  endtask

  // full register set, only written while idle
  task automatic load_poly(input int c0, input int c1, input int c2, input int c3,
                           input int c4, input int c5, input int tol);
    int c[prf_pkg::NumCoef];
    c = '{c0, c1, c2, c3, c4, c5};
    drain();
    for (int i = 0; i < prf_pkg::NumCoef; i++) begin
      write_reg(RegCoef0 + prf_pkg::CfgIdxW'(i), c[i]);
    end
    write_reg(prf_pkg::RegTol, tol);
    n_settings++;
  endtask

  // one request, sender idles between bursts of random length
  task automatic send_range(input int lo, input int hi);
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start      = 1'b1;
    range_low  = lo;
    range_high = hi;
    do @(negedge clk_i); while (!req_taken);
    n_requests++;
    if (burst_left == 0) start = 1'b0;
  endtask

  // small signed value in Q16.16 within +/- lim
  function automatic int small_q(input int lim);
    return $signed($urandom_range(0, 2 * lim * One)) - lim * One;
  endfunction

  function automatic int rand_coef(input int deg, input int i);
    if (i > deg) return 0;
    case ($urandom_range(0, 9))
      0:       return int'($urandom());
      1:       return 0;
      default: return small_q(4);
    endcase
  endfunction

  function automatic int rand_tol();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 32'h7FFF_FFFF;
      2:       return int'($urandom()) & 32'h7FFF_FFFF;
      3:       return 66;
      default: return $urandom_range(1, 2000);
    endcase
  endfunction

  initial begin
    int deg, lo, hi;
    n_requests = 0;
    n_settings = 0;
    burst_left = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setting: zero polynomial gives no sign change
    send_range(-One, One);
    // x^2 - 2, default tolerance: both bracket orders, a rootless range, the full range
    load_poly(-2 * One, 0, One, 0, 0, 0, 66);
    send_range(0, 2 * One);
    send_range(2 * One, 0);
    send_range(3 * One, 4 * One);
    send_range(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_range(32'sh7FFF_FFFF, 32'sh8000_0000);
    // x - 1: midpoint lands exactly on the root
    load_poly(-One, One, 0, 0, 0, 0, 66);
    send_range(0, 2 * One);
    send_range(-4 * One, 6 * One);
    // x^2 + 1: newton walks to zero and meets a flat derivative
    load_poly(One, 0, One, 0, 0, 0, 66);
    send_range(-One, One);
    // zero tolerance: each method runs until an exact stop or its iteration cap
    load_poly(-2 * One, 0, One, 0, 0, 0, 0);
    send_range(0, 2 * One);
    send_range(-7 * One, -One);
    // widest tolerance stops at once
    load_poly(-2 * One, 0, One, 0, 0, 0, 32'h7FFF_FFFF);
    send_range(0, 2 * One);
    // saturating coefficients, a dropped write to the unused index
    load_poly(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 66);
    write_reg(RegUnused, 32'hFFFF_FFFF);
    send_range(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_range(-One, One);
    send_range(0, 0);
    load_poly(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1);
    send_range(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_range(-One, 2 * One);

    // random phases, each with its own polynomial and tolerance
    for (int p = 0; p < NumPhases; p++) begin
      deg = $urandom_range(1, 5);
      load_poly(rand_coef(deg, 0), rand_coef(deg, 1), rand_coef(deg, 2),
                rand_coef(deg, 3), rand_coef(deg, 4), rand_coef(deg, 5),
                rand_tol());
      if (p == 0) write_reg(RegUnused, $urandom());
      for (int n = 0; n < PerPhase; n++) begin
        case ($urandom_range(0, 9))
          0: begin
            lo = int'($urandom());
            hi = int'($urandom());
          end
          1: begin
            lo = small_q(8);
            hi = lo - $urandom_range(0, 4 * One);
          end
          default: begin
            lo = small_q(8);
            hi = lo + $urandom_range(1, 8 * One);
          end
        endcase
        send_range(lo, hi);
      end
    end

    drain();
    repeat (50) @(negedge clk_i);
    $display("covered %0d requests over %0d register settings, %0d results compared",
             n_requests, n_settings, checked);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #60_000_000;
    $display("timeout waiting for results");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
